// ----- rtl/rrts_pkg.sv -----
// shared types and constants for the round robin thread slot scheduler
`default_nettype none
package rrts_pkg;

   localparam int SLOTS       = 4;
   localparam int SLOT_W      = 2;
   localparam int ADDR_W      = 48;
   localparam int STACK_BYTES = 8192;
   localparam int STACK_SHIFT = $clog2(STACK_BYTES);

   typedef enum logic [1:0] {
      ST_FREE     = 2'd0,
      ST_RUNNING  = 2'd1,
      ST_RUNNABLE = 2'd2
   } slot_state_type;

   typedef enum logic [1:0] {
      ACT_CREATE   = 2'd0,
      ACT_YIELD    = 2'd1,
      ACT_EXIT     = 2'd2,
      ACT_SCHEDULE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK          = 2'd0,
      STAT_NO_FREE     = 2'd1,
      STAT_NO_RUNNABLE = 2'd2
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_state_type;

   typedef struct packed {
      action_type          action;
      logic [ADDR_W-1:0]   entry_addr;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
      logic [SLOT_W-1:0]   prev_slot;
      logic                switched;
      logic [ADDR_W-1:0]   launch_addr;
      logic [ADDR_W-1:0]   stack_top;
   } rsp_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic run_create;
      logic mark_runnable;
      logic mark_free;
      logic run_schedule;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      action_type action;
   } stat_type;

endpackage
`default_nettype wire

// ----- rtl/round_robin_thread_slot_scheduler_unit.sv -----
// top level of the round robin thread slot scheduler
`default_nettype none
// a request (create, yield, exit or schedule) is taken when start is high and
// busy is low; it is captured on acceptance and executed in the next cycle,
// where the slot searches over the four slots run in one pass of the datapath,
// so busy is high only in that exec cycle and no new request is taken while one
// executes. the response is on the ports in the cycle after the exec cycle,
// marked by rsp_valid for exactly one cycle; the receiver cannot stall it and
// must take it then. the next request may be accepted in the same cycle as that
// response.
// stack_base is written through csr_wr_en/csr_wr_data and must only change
// while no request is in flight
module round_robin_thread_slot_scheduler_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          start,
   output      logic                          busy,
   input  wire rrts_pkg::req_type             req_payload,
   // response channel
   output      logic                          rsp_valid,
   output      rrts_pkg::rsp_type             rsp_payload,
   // stack base register
   input  wire logic                          csr_wr_en,
   input  wire logic [rrts_pkg::ADDR_W-1:0]   csr_wr_data
);

   rrts_pkg::cmd_type  cmd;
   rrts_pkg::stat_type stat;

   // sequencing of capture and execute
   rrts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // slot table, searches and response register
   rrts_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // a response always follows an exec cycle
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a preceding exec cycle");

   // a switch is only reported for a successful schedule
   a_switch_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.switched |-> rsp_payload.status == rrts_pkg::STAT_OK)
      else $error("switch reported on a failed request");

endmodule
`default_nettype wire

// ----- rtl/rrts_ctrl.sv -----
// controller state machine: sequences capture and execution of a request
`default_nettype none
module rrts_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire rrts_pkg::stat_type stat,
   output      rrts_pkg::cmd_type  cmd
);

   rrts_pkg::fsm_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrts_pkg::FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      busy     = 1'b0;
      cmd      = '0;
      case (state_ff)
         rrts_pkg::FSM_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = rrts_pkg::FSM_EXEC;
            end
         end
         rrts_pkg::FSM_EXEC: begin
            busy = 1'b1;
            case (stat.action)
               rrts_pkg::ACT_CREATE: begin
                  cmd.run_create = 1'b1;
               end
               rrts_pkg::ACT_YIELD: begin
                  cmd.mark_runnable = 1'b1;
                  cmd.run_schedule  = 1'b1;
               end
               rrts_pkg::ACT_EXIT: begin
                  cmd.mark_free    = 1'b1;
                  cmd.run_schedule = 1'b1;
               end
               default: begin
                  cmd.run_schedule = 1'b1;
               end
            endcase
            state_in = rrts_pkg::FSM_IDLE;
         end
         default: begin
            state_in = rrts_pkg::FSM_IDLE;
         end
      endcase
   end

   a_exec_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == rrts_pkg::FSM_EXEC |=> state_ff == rrts_pkg::FSM_IDLE)
      else $error("exec state held longer than one cycle");

   a_start_taken: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> state_ff == rrts_pkg::FSM_EXEC)
      else $error("accepted request did not enter exec");

endmodule
`default_nettype wire

// ----- rtl/rrts_dp.sv -----
// datapath: slot states, current slot, searches and response register
`default_nettype none
module rrts_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire rrts_pkg::req_type                 req_payload,
   input  wire logic                              csr_wr_en,
   input  wire logic [rrts_pkg::ADDR_W-1:0]       csr_wr_data,
   input  wire rrts_pkg::cmd_type                 cmd,
   output      rrts_pkg::stat_type                stat,
   output      logic                              rsp_valid,
   output      rrts_pkg::rsp_type                 rsp_payload
);

   rrts_pkg::slot_state_type            state_ff [rrts_pkg::SLOTS];
   rrts_pkg::slot_state_type            state_in [rrts_pkg::SLOTS];
   rrts_pkg::slot_state_type            marked   [rrts_pkg::SLOTS];
   logic [rrts_pkg::SLOT_W-1:0]         current_ff, current_in;
   logic [rrts_pkg::ADDR_W-1:0]         stack_base_ff;
   rrts_pkg::action_type                action_ff;
   logic [rrts_pkg::ADDR_W-1:0]         entry_ff;
   rrts_pkg::rsp_type                   rsp_ff, rsp_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic                                free_found;
   logic [rrts_pkg::SLOT_W-1:0]         free_idx;
   logic                                run_found;
   logic [rrts_pkg::SLOT_W-1:0]         run_idx;
   logic [rrts_pkg::SLOT_W-1:0]         cand;
   logic [rrts_pkg::SLOT_W:0]           slot_num;
   logic [rrts_pkg::ADDR_W-1:0]         stack_off;
   logic                                commit;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rrts_pkg::SLOTS; i++) begin
            state_ff[i] <= rrts_pkg::ST_FREE;
         end
         state_ff[0]   <= rrts_pkg::ST_RUNNING;
         current_ff    <= '0;
         stack_base_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (commit) begin
            for (int i = 0; i < rrts_pkg::SLOTS; i++) begin
               state_ff[i] <= state_in[i];
            end
            current_ff <= current_in;
         end
         if (csr_wr_en) begin
            stack_base_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_payload.action;
         entry_ff  <= req_payload.entry_addr;
      end
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   always_comb begin
      commit       = cmd.run_create | cmd.run_schedule;
      rsp_valid_in = commit;

      // current slot marked before the search
      for (int i = 0; i < rrts_pkg::SLOTS; i++) begin
         marked[i] = state_ff[i];
      end
      if (cmd.mark_runnable) begin
         marked[current_ff] = rrts_pkg::ST_RUNNABLE;
      end
      if (cmd.mark_free) begin
         marked[current_ff] = rrts_pkg::ST_FREE;
      end

      // lowest free slot
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = rrts_pkg::SLOTS - 1; i >= 0; i--) begin
         if (state_ff[i] == rrts_pkg::ST_FREE) begin
            free_found = 1'b1;
            free_idx   = rrts_pkg::SLOT_W'(i);
         end
      end

      // round robin from current+1, current slot last
      run_found = 1'b0;
      run_idx   = '0;
      for (int k = rrts_pkg::SLOTS; k >= 1; k--) begin
         cand = rrts_pkg::SLOT_W'((int'(current_ff) + k) % rrts_pkg::SLOTS);
         if (marked[cand] == rrts_pkg::ST_RUNNABLE) begin
            run_found = 1'b1;
            run_idx   = cand;
         end
      end

      slot_num  = {1'b0, free_idx} + (rrts_pkg::SLOT_W + 1)'(1);
      stack_off = rrts_pkg::ADDR_W'(slot_num) << rrts_pkg::STACK_SHIFT;

      for (int i = 0; i < rrts_pkg::SLOTS; i++) begin
         state_in[i] = state_ff[i];
      end
      current_in         = current_ff;
      rsp_in             = '0;
      rsp_in.status      = rrts_pkg::STAT_OK;
      rsp_in.prev_slot   = current_ff;

      if (cmd.run_create) begin
         if (free_found) begin
            state_in[free_idx] = rrts_pkg::ST_RUNNABLE;
            rsp_in.slot        = free_idx;
            rsp_in.launch_addr = entry_ff;
            rsp_in.stack_top   = stack_base_ff + stack_off;
         end else begin
            rsp_in.status = rrts_pkg::STAT_NO_FREE;
         end
      end

      if (cmd.run_schedule) begin
         for (int i = 0; i < rrts_pkg::SLOTS; i++) begin
            state_in[i] = marked[i];
         end
         if (run_found) begin
            state_in[run_idx] = rrts_pkg::ST_RUNNING;
            current_in        = run_idx;
            rsp_in.slot       = run_idx;
            rsp_in.switched   = (run_idx != current_ff);
         end else begin
            rsp_in.status = rrts_pkg::STAT_NO_RUNNABLE;
            rsp_in.slot   = current_ff;
         end
      end
   end

   assign stat.action = action_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
